### rtl/lss_pkg.sv
// Package for the launcher shot sequencer: constants, codes and word types.
`timescale 1ns / 1ps
package lss_pkg;

  localparam int TIMER_WIDTH = 32;
  localparam int CMP_W       = (TIMER_WIDTH > 32) ? TIMER_WIDTH : 32;

  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_TARGET = 3'd1;
  localparam logic [2:0] KIND_MOTOR  = 3'd2;
  localparam logic [2:0] KIND_AIM    = 3'd3;
  localparam logic [2:0] KIND_ABORT  = 3'd4;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_TARGET = 3'd1;
  localparam logic [2:0] PH_WAIT   = 3'd2;
  localparam logic [2:0] PH_SHOOT  = 3'd3;
  localparam logic [2:0] PH_ABORT  = 3'd4;

  localparam logic [2:0] CFG_MIN_YAW      = 3'd0;
  localparam logic [2:0] CFG_MAX_YAW      = 3'd1;
  localparam logic [2:0] CFG_MAX_VELOCITY = 3'd2;
  localparam logic [2:0] CFG_CMD_TIMEOUT  = 3'd3;
  localparam logic [2:0] CFG_COOLDOWN     = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [16:0] target_yaw;
    logic signed [15:0] target_speed;
    logic               target_above;
    logic               ready_value;
  } lss_item_t;

  typedef struct packed {
    logic [2:0]         reported_state;
    logic               yaw_cmd_valid;
    logic signed [7:0]  yaw_cmd;
    logic               speed_cmd_valid;
    logic signed [15:0] speed_cmd;
    logic               trigger;
    logic               shot_done;
    logic               yaw_rejected;
    logic               speed_rejected;
  } lss_result_t;

  typedef struct packed {
    logic signed [16:0] min_yaw;
    logic signed [16:0] max_yaw;
    logic [14:0]        max_velocity;
    logic [31:0]        resend_limit;
    logic [31:0]        cooldown_ticks;
  } lss_cfg_t;

endpackage

### rtl/lss_if.sv
// Valid/ready channel interfaces for input and result words.
`timescale 1ns / 1ps
interface lss_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [16:0] target_yaw;
  logic signed [15:0] target_speed;
  logic               target_above;
  logic               ready_value;

  modport source (output valid, kind, target_yaw, target_speed, target_above, ready_value,
                  input ready);
  modport sink (input valid, kind, target_yaw, target_speed, target_above, ready_value,
                output ready);
endinterface

interface lss_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         reported_state;
  logic               yaw_cmd_valid;
  logic signed [7:0]  yaw_cmd;
  logic               speed_cmd_valid;
  logic signed [15:0] speed_cmd;
  logic               trigger;
  logic               shot_done;
  logic               yaw_rejected;
  logic               speed_rejected;

  modport source (output valid, reported_state, yaw_cmd_valid, yaw_cmd, speed_cmd_valid,
                  speed_cmd, trigger, shot_done, yaw_rejected, speed_rejected,
                  input ready);
  modport sink (input valid, reported_state, yaw_cmd_valid, yaw_cmd, speed_cmd_valid,
                speed_cmd, trigger, shot_done, yaw_rejected, speed_rejected,
                output ready);
endinterface

### rtl/lss_cfg_regs.sv
// Configuration register file for the shot sequencer.
`timescale 1ns / 1ps
module lss_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lss_pkg::CFG_DATA_W-1:0] cfg_data,
  output lss_pkg::lss_cfg_t             cfg
);
  import lss_pkg::*;

  lss_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_yaw         <= -17'sd23040;
      cfg_r.max_yaw         <= 17'sd23040;
      cfg_r.max_velocity    <= 15'd10000;
      cfg_r.resend_limit    <= 32'd1000;
      cfg_r.cooldown_ticks  <= 32'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_YAW:      cfg_r.min_yaw         <= cfg_data[16:0];
        CFG_MAX_YAW:      cfg_r.max_yaw         <= cfg_data[16:0];
        CFG_MAX_VELOCITY: cfg_r.max_velocity    <= cfg_data[14:0];
        CFG_CMD_TIMEOUT:  cfg_r.resend_limit    <= cfg_data[31:0];
        CFG_COOLDOWN:     cfg_r.cooldown_ticks  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/lss_step.sv
// Sequencer state and the per-word update and result logic.
`timescale 1ns / 1ps
module lss_step (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  lss_pkg::lss_item_t   item,
  input  lss_pkg::lss_cfg_t    cfg,
  output lss_pkg::lss_result_t res
);
  import lss_pkg::*;

  logic [2:0]             phase_r, phase_nxt;
  logic                   tgt_pend_r, tgt_pend_nxt;
  logic                   abt_pend_r, abt_pend_nxt;
  logic                   motor_r, motor_nxt;
  logic                   aim_r, aim_nxt;
  logic signed [16:0]     yaw_r, yaw_nxt;
  logic signed [15:0]     speed_r, speed_nxt;
  logic [TIMER_WIDTH-1:0] elapsed_r, elapsed_nxt;

  logic [TIMER_WIDTH-1:0] elapsed_inc;
  logic                   yaw_ok, speed_ok;
  logic signed [16:0]     yaw_q;
  logic signed [7:0]      yaw_sat;

  assign elapsed_inc = (&elapsed_r) ? elapsed_r : elapsed_r + 1'b1;

  assign yaw_ok   = (cfg.min_yaw < item.target_yaw) && (item.target_yaw < cfg.max_yaw);
  assign speed_ok = !item.target_speed[15] &&
                    (item.target_speed < $signed({1'b0, cfg.max_velocity}));

  // divide by 256 rounding toward zero, then clamp to 8 bits
  always_comb begin
    yaw_q = yaw_r >>> 8;
    if (yaw_r[16] && (|yaw_r[7:0])) yaw_q = yaw_q + 17'sd1;
    if (yaw_q > 17'sd127)       yaw_sat = 8'sd127;
    else if (yaw_q < -17'sd128) yaw_sat = -8'sd128;
    else                        yaw_sat = yaw_q[7:0];
  end

  always_comb begin
    phase_nxt    = phase_r;
    tgt_pend_nxt = tgt_pend_r;
    abt_pend_nxt = abt_pend_r;
    motor_nxt    = motor_r;
    aim_nxt      = aim_r;
    yaw_nxt      = yaw_r;
    speed_nxt    = speed_r;
    elapsed_nxt  = elapsed_r;
    res          = '0;
    res.reported_state = phase_r;

    unique case (item.kind)
      KIND_TARGET: begin
        if (!item.target_above) begin
          yaw_nxt   = item.target_yaw;
          speed_nxt = item.target_speed;
          if (yaw_ok && speed_ok) begin
            tgt_pend_nxt = 1'b1;
            abt_pend_nxt = 1'b0;
          end else begin
            tgt_pend_nxt = 1'b0;
          end
          res.yaw_rejected   = !yaw_ok;
          res.speed_rejected = !speed_ok;
        end
      end
      KIND_MOTOR: motor_nxt = item.ready_value;
      KIND_AIM:   aim_nxt   = item.ready_value;
      KIND_ABORT: begin
        abt_pend_nxt = 1'b1;
        tgt_pend_nxt = 1'b0;
      end
      KIND_TICK: begin
        unique case (phase_r)
          PH_TARGET: begin
            if (abt_pend_r) begin
              abt_pend_nxt = 1'b0;
              phase_nxt    = PH_ABORT;
            end else if (tgt_pend_r) begin
              tgt_pend_nxt = 1'b0;
            end else begin
              res.yaw_cmd_valid   = 1'b1;
              res.yaw_cmd         = yaw_sat;
              res.speed_cmd_valid = 1'b1;
              res.speed_cmd       = speed_r;
              elapsed_nxt         = '0;
              phase_nxt           = PH_WAIT;
            end
          end
          PH_WAIT: begin
            if (abt_pend_r) begin
              abt_pend_nxt = 1'b0;
              phase_nxt    = PH_ABORT;
            end else if (tgt_pend_r) begin
              tgt_pend_nxt = 1'b0;
              phase_nxt    = PH_TARGET;
            end else begin
              elapsed_nxt = elapsed_inc;
              if (CMP_W'(elapsed_inc) > CMP_W'(cfg.resend_limit)) phase_nxt = PH_TARGET;
              if (motor_r && aim_r) begin
                res.trigger = 1'b1;
                elapsed_nxt = '0;
                phase_nxt   = PH_SHOOT;
              end
            end
          end
          PH_SHOOT: begin
            elapsed_nxt = elapsed_inc;
            if (CMP_W'(elapsed_inc) > CMP_W'(cfg.cooldown_ticks)) begin
              res.shot_done = 1'b1;
              phase_nxt     = PH_IDLE;
            end
          end
          PH_ABORT: begin
            res.speed_cmd_valid = 1'b1;
            res.speed_cmd       = '0;
            phase_nxt           = PH_IDLE;
          end
          default: begin
            if (tgt_pend_r) begin
              tgt_pend_nxt = 1'b0;
              phase_nxt    = PH_TARGET;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      tgt_pend_r <= 1'b0;
      abt_pend_r <= 1'b0;
      motor_r    <= 1'b0;
      aim_r      <= 1'b0;
      yaw_r      <= '0;
      speed_r    <= '0;
      elapsed_r  <= '0;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      tgt_pend_r <= tgt_pend_nxt;
      abt_pend_r <= abt_pend_nxt;
      motor_r    <= motor_nxt;
      aim_r      <= aim_nxt;
      yaw_r      <= yaw_nxt;
      speed_r    <= speed_nxt;
      elapsed_r  <= elapsed_nxt;
    end
  end

endmodule

### rtl/launcher_shot_sequencer_unit.sv
// Top level of the launcher shot sequencer: input register, step logic, result register.
// An accepted word waits in the input register; its result is loaded into the result register.
// Throughput: one word per cycle while out_chan.ready does not stall the result register.
// The input register keeps accepting while a result waits; ready falls only when both are full.
// Reset: synchronous active-low rst_n clears both stages, the sequencer state and the registers
// to their defaults.
`timescale 1ns / 1ps
module launcher_shot_sequencer_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  lss_in_if.sink                         in_chan,
  lss_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [lss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lss_pkg::*;

  lss_item_t   item_r;
  logic        item_valid_r;
  lss_result_t res_r;
  lss_result_t step_res;
  logic        out_valid_r;
  lss_cfg_t    cfg;
  logic        out_load;
  logic        in_take;

  assign out_load = item_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !item_valid_r || out_load;
  assign in_take = in_chan.valid && in_chan.ready;

  lss_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lss_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (out_load),
    .item    (item_r),
    .cfg     (cfg),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_take) begin
      item_valid_r <= 1'b1;
    end else if (out_load) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.kind         <= in_chan.kind;
      item_r.target_yaw   <= in_chan.target_yaw;
      item_r.target_speed <= in_chan.target_speed;
      item_r.target_above <= in_chan.target_above;
      item_r.ready_value  <= in_chan.ready_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) res_r <= step_res;
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.reported_state  = res_r.reported_state;
  assign out_chan.yaw_cmd_valid   = res_r.yaw_cmd_valid;
  assign out_chan.yaw_cmd         = res_r.yaw_cmd;
  assign out_chan.speed_cmd_valid = res_r.speed_cmd_valid;
  assign out_chan.speed_cmd       = res_r.speed_cmd;
  assign out_chan.trigger         = res_r.trigger;
  assign out_chan.shot_done       = res_r.shot_done;
  assign out_chan.yaw_rejected    = res_r.yaw_rejected;
  assign out_chan.speed_rejected  = res_r.speed_rejected;

`ifndef SYNTHESIS
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("result word lost after step");

  a_trigger_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.trigger) |-> (res_r.reported_state == PH_WAIT))
    else $error("trigger outside wait");

  a_done_from_shoot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.shot_done) |-> (res_r.reported_state == PH_SHOOT))
    else $error("shot_done outside shoot");

  a_yaw_cmd_from_target: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.yaw_cmd_valid) |->
      (res_r.reported_state == PH_TARGET && res_r.speed_cmd_valid))
    else $error("yaw command outside target phase");
`endif

endmodule
